@@ rtl/psvm_pkg.sv @@
// Shared types and constants of the polyphonic sample voice mixer.
package psvm_pkg;

  localparam logic [2:0] OP_WRITE_WORD = 3'd0;
  localparam logic [2:0] OP_WRITE_DESC = 3'd1;
  localparam logic [2:0] OP_VOICE_ON   = 3'd2;
  localparam logic [2:0] OP_VOICE_OFF  = 3'd3;
  localparam logic [2:0] OP_TICK       = 3'd4;

  localparam logic [1:0] CFG_OUTPUT_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_BLOCK_FRAMES    = 2'd1;
  localparam logic [1:0] CFG_RELEASE_FLOOR   = 2'd2;

  localparam logic [1:0]  RESET_OUTPUT_CHANNELS = 2'd2;
  localparam logic [10:0] RESET_BLOCK_FRAMES    = 11'd64;
  localparam logic [15:0] RESET_RELEASE_FLOOR   = 16'd328;

  localparam logic [15:0] GAIN_ONE = 16'h8000;

  typedef struct packed {
    logic [2:0]         op;
    logic [6:0]         sample_id;
    logic [15:0]        voice_tag;
    logic [15:0]        address;
    logic [16:0]        end_address;
    logic [1:0]         channels;
    logic [19:0]        release_frames;
    logic [15:0]        intensity;
    logic signed [15:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic [4:0]         voices_busy;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  output_channels;
    logic [10:0] block_frames;
    logic [15:0] release_floor;
  } cfg_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_WORD,
    K_DESC,
    K_ON,
    K_OFF,
    K_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [6:0]         sid;
    logic [15:0]        tag;
    logic [15:0]        address;
    logic [16:0]        end_addr;
    logic [1:0]         chans;
    logic [19:0]        release_len;
    logic [15:0]        gain;
    logic signed [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [15:0] start;
    logic [16:0] end_addr;
    logic [1:0]  chans;
    logic [19:0] release_len;
  } desc_t;

endpackage

@@ rtl/psvm_ram.sv @@
// Generic single-port-write, registered-read RAM.
module psvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/psvm_fade.sv @@
// Iterative release multiplier: 32768 - floor(num * 32768 / den), clamped at zero.
module psvm_fade (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [10:0] num,
  input  logic [20:0] den,
  output logic        done,
  output logic [15:0] rm
);

  localparam int STEPS = 15;

  logic        busy;
  logic [3:0]  cnt;
  logic [20:0] rem;
  logic [20:0] den_r;
  logic [14:0] quo;
  logic [21:0] rem_sh;
  logic        take;

  assign rem_sh = {rem, 1'b0};
  assign take   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_r <= den;
        if (den == 21'd0 || {10'b0, num} >= den) begin
          rm   <= 16'd0;
          done <= 1'b1;
        end else begin
          rem  <= {10'b0, num};
          quo  <= 15'd0;
          cnt  <= 4'(STEPS - 1);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= take ? 21'(rem_sh - {1'b0, den_r}) : rem_sh[20:0];
        quo <= {quo[13:0], take};
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          rm   <= psvm_pkg::GAIN_ONE - {1'b0, quo[13:0], take};
        end else begin
          cnt <= cnt - 4'd1;
        end
      end
    end
  end

endmodule

@@ rtl/psvm_front.sv @@
// Input stage: accept items, classify and clean them, and queue them for the engine.
module psvm_front #(
  parameter int SAMPLE_IDS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  psvm_pkg::in_item_t in_data,
  output logic               head_valid,
  output psvm_pkg::cmd_t     head,
  input  logic               pop
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  psvm_pkg::cmd_t q [DEPTH];
  logic [PW-1:0]  wp, rp;
  logic [PW:0]    count;
  psvm_pkg::cmd_t cmd;
  logic           sid_ok;
  logic           push;
  logic           take;

  assign sid_ok = {2'b0, in_data.sample_id} < 9'(SAMPLE_IDS);

  always_comb begin
    cmd.sid         = in_data.sample_id;
    cmd.tag         = in_data.voice_tag;
    cmd.address     = in_data.address;
    cmd.end_addr    = in_data.end_address;
    cmd.release_len = in_data.release_frames;
    cmd.value       = in_data.sample_value;
    cmd.gain        = (in_data.intensity > psvm_pkg::GAIN_ONE) ? psvm_pkg::GAIN_ONE
                                                               : in_data.intensity;
    unique case (in_data.channels)
      2'd0:    cmd.chans = 2'd1;
      2'd3:    cmd.chans = 2'd2;
      default: cmd.chans = in_data.channels;
    endcase
    unique case (in_data.op)
      psvm_pkg::OP_WRITE_WORD: cmd.kind = psvm_pkg::K_WORD;
      psvm_pkg::OP_WRITE_DESC: cmd.kind = sid_ok ? psvm_pkg::K_DESC : psvm_pkg::K_NONE;
      psvm_pkg::OP_VOICE_ON:   cmd.kind = sid_ok ? psvm_pkg::K_ON : psvm_pkg::K_NONE;
      psvm_pkg::OP_VOICE_OFF:  cmd.kind = psvm_pkg::K_OFF;
      psvm_pkg::OP_TICK:       cmd.kind = psvm_pkg::K_TICK;
      default:                 cmd.kind = psvm_pkg::K_NONE;
    endcase
  end

  assign in_ready   = count != (PW + 1)'(DEPTH);
  assign head_valid = count != '0;
  assign head       = q[rp];
  assign take       = pop && head_valid;
  assign push       = in_valid && in_ready && cmd.kind != psvm_pkg::K_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        q[wp] <= cmd;
        wp    <= wp + 1'b1;
      end
      if (take) begin
        rp <= rp + 1'b1;
      end
      unique case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/psvm_engine.sv @@
// Back end: memories, voice slots, and the per-frame mix walk over all slots.
module psvm_engine #(
  parameter int VOICE_SLOTS  = 16,
  parameter int SAMPLE_WORDS = 65536,
  parameter int SAMPLE_IDS   = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  psvm_pkg::cfg_t      cfg,
  input  logic                head_valid,
  input  psvm_pkg::cmd_t      head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output psvm_pkg::out_item_t out_data
);

  localparam int SLOT_W = VOICE_SLOTS > 1 ? $clog2(VOICE_SLOTS) : 1;
  localparam int DID_W  = SAMPLE_IDS > 1 ? $clog2(SAMPLE_IDS) : 1;
  localparam int SAW    = SAMPLE_WORDS > 1 ? $clog2(SAMPLE_WORDS) : 1;
  localparam int ACC_W  = 19 + SLOT_W;
  localparam int CNT_W  = $clog2(VOICE_SLOTS + 1);

  typedef enum logic [1:0] {
    M_IDLE,
    M_PLAY,
    M_REL
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ON_SCAN,
    S_OFF_SCAN,
    S_T_SLOT,
    S_T_DIV,
    S_T_RD0,
    S_T_RD1,
    S_T_MUL1,
    S_T_MUL2,
    S_T_ACC,
    S_T_POST,
    S_T_DIVB,
    S_T_GAIN,
    S_T_NEXT,
    S_T_OUT
  } state_t;

  state_t state;

  mode_t       mode      [VOICE_SLOTS];
  logic [15:0] slot_tag  [VOICE_SLOTS];
  logic [16:0] slot_pos  [VOICE_SLOTS];
  logic [16:0] slot_end  [VOICE_SLOTS];
  logic [1:0]  slot_ch   [VOICE_SLOTS];
  logic [15:0] slot_gain [VOICE_SLOTS];
  logic [20:0] slot_rel  [VOICE_SLOTS];
  logic [SAMPLE_IDS-1:0] desc_valid;

  psvm_pkg::cmd_t   cur;
  logic [SLOT_W-1:0] slot;
  logic              last_slot;
  logic              och2;
  logic [10:0]       bf;
  logic [9:0]        n;
  logic              bend;
  logic [9:0]        frame_in_block;
  logic signed [ACC_W-1:0] acc0, acc1;
  logic [CNT_W-1:0]  busy;
  logic [15:0]       rm_r;
  logic [30:0]       gr_r;
  logic signed [15:0] w0;
  logic signed [49:0] prod_r;
  logic              ch_sel;

  logic [10:0] bf_cfg;
  logic [8:0]  sid_x;
  logic [DID_W-1:0] did;
  logic [SAW+15:0] waddr_x;
  logic [SAW+16:0] raddr_x;
  logic [16:0]     rpos;

  logic [15:0]       word_rd;
  logic [$bits(psvm_pkg::desc_t)-1:0] desc_rd;
  psvm_pkg::desc_t   desc_w, desc_r;
  logic              word_we, desc_we, word_re, desc_re;

  logic        fade_start, fade_done;
  logic [10:0] fade_num;
  logic [15:0] fade_rm;

  logic               copy;
  logic signed [16:0] opnd;
  logic               k31;
  logic signed [49:0] rounded, shifted;
  logic signed [ACC_W-1:0] contrib;
  logic [31:0]        gprod;
  logic [7:0]         busy_x;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32767)) begin
      return 16'sh7fff;
    end else if (v < -ACC_W'(32768)) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  always_comb begin
    if (cfg.block_frames == 11'd0) begin
      bf_cfg = 11'd1;
    end else if (cfg.block_frames > 11'd1024) begin
      bf_cfg = 11'd1024;
    end else begin
      bf_cfg = cfg.block_frames;
    end
  end

  assign last_slot = slot == SLOT_W'(VOICE_SLOTS - 1);
  assign pop       = state == S_IDLE && head_valid;

  assign sid_x   = {2'b0, head.sid};
  assign did     = sid_x[DID_W-1:0];
  assign waddr_x = {{SAW{1'b0}}, head.address};
  assign rpos    = (state == S_T_RD1) ? 17'(slot_pos[slot] + 17'd1) : slot_pos[slot];
  assign raddr_x = {{SAW{1'b0}}, rpos};

  assign word_we = pop && head.kind == psvm_pkg::K_WORD;
  assign desc_we = pop && head.kind == psvm_pkg::K_DESC;
  assign desc_re = pop && head.kind == psvm_pkg::K_ON;
  assign word_re = state == S_T_RD0 || state == S_T_RD1;

  assign desc_w.start       = head.address;
  assign desc_w.end_addr    = head.end_addr;
  assign desc_w.chans       = head.chans;
  assign desc_w.release_len = head.release_len;
  assign desc_r             = desc_rd;

  psvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_words (
    .clk   (clk),
    .we    (word_we),
    .waddr (waddr_x[SAW-1:0]),
    .wdata (head.value),
    .re    (word_re),
    .raddr (raddr_x[SAW-1:0]),
    .rdata (word_rd)
  );

  psvm_ram #(.WIDTH($bits(psvm_pkg::desc_t)), .DEPTH(SAMPLE_IDS)) u_desc (
    .clk   (clk),
    .we    (desc_we),
    .waddr (did),
    .wdata (desc_w),
    .re    (desc_re),
    .raddr (did),
    .rdata (desc_rd)
  );

  assign fade_start = (state == S_T_SLOT && mode[slot] == M_REL
                       && slot_pos[slot] < slot_end[slot])
                   || (state == S_T_POST && mode[slot] == M_REL && bend
                       && slot_pos[slot] < slot_end[slot]);
  assign fade_num   = (state == S_T_POST) ? bf : {1'b0, n};

  psvm_fade u_fade (
    .clk   (clk),
    .rst   (rst),
    .start (fade_start),
    .num   (fade_num),
    .den   (slot_rel[slot]),
    .done  (fade_done),
    .rm    (fade_rm)
  );

  assign copy = slot_ch[slot] == (och2 ? 2'd2 : 2'd1);
  assign k31  = !copy && och2;

  always_comb begin
    if (copy) begin
      opnd = ch_sel ? {word_rd[15], word_rd} : {w0[15], w0};
    end else if (slot_ch[slot] == 2'd2) begin
      opnd = 17'({w0[15], w0} + {word_rd[15], word_rd});
    end else begin
      opnd = {w0[15], w0};
    end
  end

  assign rounded = prod_r + (k31 ? (50'sd1 <<< 30) : (50'sd1 <<< 29));
  assign shifted = k31 ? (rounded >>> 31) : (rounded >>> 30);
  assign contrib = shifted[ACC_W-1:0];
  assign gprod   = slot_gain[slot] * fade_rm;
  assign busy_x  = 8'(busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      frame_in_block <= '0;
      desc_valid     <= '0;
      for (int k = 0; k < VOICE_SLOTS; k++) begin
        mode[k] <= M_IDLE;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            cur  <= head;
            slot <= '0;
            unique case (head.kind)
              psvm_pkg::K_DESC: desc_valid[did] <= 1'b1;
              psvm_pkg::K_ON: begin
                if (desc_valid[did]) begin
                  state <= S_ON_SCAN;
                end
              end
              psvm_pkg::K_OFF: state <= S_OFF_SCAN;
              psvm_pkg::K_TICK: begin
                och2  <= cfg.output_channels[1];
                bf    <= bf_cfg;
                n     <= frame_in_block;
                bend  <= 11'({1'b0, frame_in_block} + 11'd1) >= bf_cfg;
                acc0  <= '0;
                acc1  <= '0;
                busy  <= '0;
                state <= S_T_SLOT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ON_SCAN: begin
          if (mode[slot] == M_IDLE) begin
            mode[slot]      <= M_PLAY;
            slot_tag[slot]  <= cur.tag;
            slot_pos[slot]  <= {1'b0, desc_r.start};
            slot_end[slot]  <= desc_r.end_addr;
            slot_ch[slot]   <= desc_r.chans;
            slot_gain[slot] <= cur.gain;
            slot_rel[slot]  <= {1'b0, desc_r.release_len};
            state           <= S_IDLE;
          end else if (last_slot) begin
            state <= S_IDLE;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_OFF_SCAN: begin
          if (mode[slot] == M_PLAY && slot_tag[slot] == cur.tag) begin
            mode[slot] <= M_REL;
            state      <= S_IDLE;
          end else if (last_slot) begin
            state <= S_IDLE;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_T_SLOT: begin
          ch_sel <= 1'b0;
          if (mode[slot] == M_IDLE) begin
            state <= S_T_NEXT;
          end else if (slot_pos[slot] >= slot_end[slot]) begin
            mode[slot] <= M_IDLE;
            state      <= S_T_NEXT;
          end else if (mode[slot] == M_REL) begin
            state <= S_T_DIV;
          end else begin
            rm_r  <= psvm_pkg::GAIN_ONE;
            state <= S_T_RD0;
          end
        end
        S_T_DIV: begin
          if (fade_done) begin
            rm_r  <= fade_rm;
            state <= S_T_RD0;
          end
        end
        S_T_RD0: state <= S_T_RD1;
        S_T_RD1: begin
          w0    <= word_rd;
          state <= S_T_MUL1;
        end
        S_T_MUL1: begin
          gr_r  <= 31'(slot_gain[slot] * rm_r);
          state <= S_T_MUL2;
        end
        S_T_MUL2: begin
          prod_r <= $signed({1'b0, gr_r}) * opnd;
          state  <= S_T_ACC;
        end
        S_T_ACC: begin
          if (copy) begin
            if (ch_sel) begin
              acc1 <= acc1 + contrib;
            end else begin
              acc0 <= acc0 + contrib;
            end
            if (och2 && !ch_sel) begin
              ch_sel <= 1'b1;
              state  <= S_T_MUL2;
            end else begin
              slot_pos[slot] <= 17'(slot_pos[slot] + {15'd0, slot_ch[slot]});
              state          <= S_T_POST;
            end
          end else begin
            acc0 <= acc0 + contrib;
            if (och2) begin
              acc1 <= acc1 + contrib;
            end
            slot_pos[slot] <= 17'(slot_pos[slot] + {15'd0, slot_ch[slot]});
            state          <= S_T_POST;
          end
        end
        S_T_POST: begin
          if (slot_pos[slot] >= slot_end[slot]) begin
            mode[slot] <= M_IDLE;
            state      <= S_T_NEXT;
          end else if (mode[slot] == M_REL && bend) begin
            state <= S_T_DIVB;
          end else begin
            busy  <= busy + 1'b1;
            state <= S_T_NEXT;
          end
        end
        S_T_DIVB: begin
          if (fade_done) begin
            slot_gain[slot] <= gprod[30:15];
            slot_rel[slot]  <= (slot_rel[slot] > {10'd0, bf})
                               ? 21'(slot_rel[slot] - {10'd0, bf}) : 21'd0;
            state           <= S_T_GAIN;
          end
        end
        S_T_GAIN: begin
          if (slot_gain[slot] <= cfg.release_floor) begin
            mode[slot] <= M_IDLE;
          end else begin
            busy <= busy + 1'b1;
          end
          state <= S_T_NEXT;
        end
        S_T_NEXT: begin
          if (last_slot) begin
            state <= S_T_OUT;
          end else begin
            slot  <= slot + 1'b1;
            state <= S_T_SLOT;
          end
        end
        S_T_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.out_left    <= sat16(acc0);
            out_data.out_right   <= och2 ? sat16(acc1) : 16'sd0;
            out_data.voices_busy <= busy_x[4:0];
            out_valid            <= 1'b1;
            frame_in_block       <= bend ? 10'd0 : 10'(n + 10'd1);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/polyphonic_sample_voice_mixer.sv @@
// Top level of the polyphonic sample voice mixer: configuration registers, input queue, engine.
//
// Items enter a four-deep queue, so the input side keeps accepting while the
// engine works, as long as the queue has room. Sample and descriptor writes
// are done as they leave the queue. Voice on and voice off walk the slot
// table from slot zero until they find their slot or reach the last one. A
// frame tick walks every slot: an idle slot is skipped, a playing voice reads
// its sample words and is scaled and mixed in (the sample memory port and the
// gain multiplier are shared), and a releasing voice also waits for the fade
// division, and for it again at a block end. The mixed frame waits in an
// output register until it is taken. Sample memory is undefined until
// written.
module polyphonic_sample_voice_mixer #(
  parameter int VOICE_SLOTS  = 16,
  parameter int SAMPLE_WORDS = 65536,
  parameter int SAMPLE_IDS   = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  psvm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output psvm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  psvm_pkg::cfg_t cfg;
  psvm_pkg::cmd_t head;
  logic           head_valid;
  logic           pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_channels <= psvm_pkg::RESET_OUTPUT_CHANNELS;
      cfg.block_frames    <= psvm_pkg::RESET_BLOCK_FRAMES;
      cfg.release_floor   <= psvm_pkg::RESET_RELEASE_FLOOR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        psvm_pkg::CFG_OUTPUT_CHANNELS: cfg.output_channels <= cfg_data[1:0];
        psvm_pkg::CFG_BLOCK_FRAMES:    cfg.block_frames    <= cfg_data[10:0];
        psvm_pkg::CFG_RELEASE_FLOOR:   cfg.release_floor   <= cfg_data;
        default:                       cfg <= cfg;
      endcase
    end
  end

  psvm_front #(.SAMPLE_IDS(SAMPLE_IDS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  psvm_engine #(
    .VOICE_SLOTS  (VOICE_SLOTS),
    .SAMPLE_WORDS (SAMPLE_WORDS),
    .SAMPLE_IDS   (SAMPLE_IDS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ tb/polyphonic_sample_voice_mixer_test.sv @@
// Self-checking testbench of the polyphonic sample voice mixer with a behavioural frame predictor.
module polyphonic_sample_voice_mixer_test;
  import psvm_pkg::*;

  localparam int NSLOT = 16;
  localparam int NSID = 128;
  localparam int WORDS = 65536;
  localparam int DRAIN_CYCLES = 1200;
  localparam longint CYCLE_LIMIT = 3000000;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_PLAY = 2'd1;
  localparam logic [1:0] MODE_REL  = 2'd2;

  typedef struct {
    bit          ok;
    logic [15:0] start;
    logic [16:0] stop;
    logic [1:0]  chans;
    logic [19:0] rel;
  } sound_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  polyphonic_sample_voice_mixer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic signed [15:0] mem [WORDS];
  bit written [WORDS];
  sound_t sounds [NSID];
  logic [1:0]  v_mode [NSLOT];
  logic [15:0] v_tag [NSLOT];
  logic [16:0] v_pos [NSLOT];
  logic [16:0] v_stop [NSLOT];
  logic [1:0]  v_chans [NSLOT];
  logic [15:0] v_gain [NSLOT];
  logic [20:0] v_left [NSLOT];
  int unsigned frame_pos;
  logic [1:0]  out_chans_reg;
  logic [10:0] block_reg;
  logic [15:0] floor_reg;

  out_item_t frames_due [$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  function automatic int unsigned fade_mult(int unsigned n, int unsigned left);
    longint unsigned q;
    if (left == 0) return 0;
    q = (longint'(n) * 32768) / left;
    return q >= 32768 ? 0 : 32768 - q;
  endfunction

  function automatic longint rshift_round(longint p, int k);
    return (p + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint word_at(logic [16:0] a);
    return longint'(mem[a[15:0]]);
  endfunction

  task automatic predict_item(in_item_t it);
    int unsigned och, bf, n, busy, rm, rb;
    longint acc0, acc1, g, o, part;
    bit bend;
    out_item_t f;
    case (it.op)
      OP_WRITE_WORD: begin
        mem[it.address] = it.sample_value;
        written[it.address] = 1'b1;
      end
      OP_WRITE_DESC: begin
        sounds[it.sample_id].ok = 1'b1;
        sounds[it.sample_id].start = it.address;
        sounds[it.sample_id].stop = it.end_address;
        sounds[it.sample_id].chans = it.channels == 0 ? 2'd1 :
                                     (it.channels == 3 ? 2'd2 : it.channels);
        sounds[it.sample_id].rel = it.release_frames;
      end
      OP_VOICE_ON: begin
        if (sounds[it.sample_id].ok) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (v_mode[i] == MODE_IDLE) begin
              v_mode[i] = MODE_PLAY;
              v_tag[i] = it.voice_tag;
              v_pos[i] = sounds[it.sample_id].start;
              v_stop[i] = sounds[it.sample_id].stop;
              v_chans[i] = sounds[it.sample_id].chans;
              v_gain[i] = it.intensity > 32768 ? 16'h8000 : it.intensity;
              v_left[i] = sounds[it.sample_id].rel;
              break;
            end
          end
        end
      end
      OP_VOICE_OFF: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (v_mode[i] == MODE_PLAY && v_tag[i] == it.voice_tag) begin
            v_mode[i] = MODE_REL;
            break;
          end
        end
      end
      OP_TICK: begin
        och = out_chans_reg == 0 ? 1 : (out_chans_reg == 3 ? 2 : out_chans_reg);
        bf = block_reg == 0 ? 1 : (block_reg > 1024 ? 1024 : block_reg);
        n = frame_pos;
        bend = (n + 1) >= bf;
        acc0 = 0;
        acc1 = 0;
        busy = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (v_mode[i] == MODE_IDLE) continue;
          if (v_pos[i] < v_stop[i]) begin
            rm = v_mode[i] == MODE_REL ? fade_mult(n, v_left[i]) : 32768;
            g = v_gain[i];
            if (v_chans[i] == och) begin
              for (int c = 0; c < och; c++) begin
                part = rshift_round(g * word_at(v_pos[i]) * rm, 30);
                v_pos[i]++;
                if (c == 0) acc0 += part;
                else acc1 += part;
              end
            end else begin
              o = 0;
              for (int c = 0; c < v_chans[i]; c++) begin
                o += word_at(v_pos[i]);
                v_pos[i]++;
              end
              part = rshift_round(g * o * rm, och == 2 ? 31 : 30);
              acc0 += part;
              if (och == 2) acc1 += part;
            end
          end
          if (v_pos[i] >= v_stop[i]) begin
            v_mode[i] = MODE_IDLE;
            continue;
          end
          if (v_mode[i] == MODE_REL && bend) begin
            rb = fade_mult(bf, v_left[i]);
            v_gain[i] = (longint'(v_gain[i]) * rb) >> 15;
            v_left[i] = v_left[i] > bf ? v_left[i] - bf : 0;
            if (v_gain[i] <= floor_reg) begin
              v_mode[i] = MODE_IDLE;
              continue;
            end
          end
          busy++;
        end
        frame_pos = bend ? 0 : n + 1;
        f.out_left = clip16(acc0);
        f.out_right = och == 2 ? clip16(acc1) : 16'sd0;
        f.voices_busy = busy[4:0];
        frames_due.push_back(f);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_item(in_data);
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $error("unexpected frame %h", out_data);
          errors++;
        end else begin
          out_item_t e;
          e = frames_due.pop_front();
          if (out_data.out_left !== e.out_left) begin
            $error("out_left expected %0d got %0d", e.out_left, out_data.out_left);
            errors++;
          end
          if (out_data.out_right !== e.out_right) begin
            $error("out_right expected %0d got %0d", e.out_right, out_data.out_right);
            errors++;
          end
          if (out_data.voices_busy !== e.voices_busy) begin
            $error("voices_busy expected %0d got %0d", e.voices_busy, out_data.voices_busy);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_item(in_item_t it);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OUTPUT_CHANNELS: out_chans_reg = val[1:0];
      CFG_BLOCK_FRAMES: block_reg = val[10:0];
      CFG_RELEASE_FLOOR: floor_reg = val;
      default: ;
    endcase
  endtask

  task automatic settle;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom};
    it.op = OP_WRITE_WORD;
    return it;
  endfunction

  task automatic put_word(logic [15:0] a, logic [15:0] v);
    in_item_t it;
    it = noise_item();
    it.address = a;
    it.sample_value = v;
    send_item(it);
  endtask

  task automatic put_desc(logic [6:0] sid, logic [15:0] a, logic [16:0] e, logic [1:0] ch,
                          logic [19:0] rl);
    in_item_t it;
    it = noise_item();
    it.op = OP_WRITE_DESC;
    it.sample_id = sid;
    it.address = a;
    it.end_address = e;
    it.channels = ch;
    it.release_frames = rl;
    send_item(it);
  endtask

  task automatic put_on(logic [6:0] sid, logic [15:0] tag, logic [15:0] g);
    in_item_t it;
    it = noise_item();
    it.op = OP_VOICE_ON;
    it.sample_id = sid;
    it.voice_tag = tag;
    it.intensity = g;
    send_item(it);
  endtask

  task automatic put_off(logic [15:0] tag);
    in_item_t it;
    it = noise_item();
    it.op = OP_VOICE_OFF;
    it.voice_tag = tag;
    send_item(it);
  endtask

  task automatic put_tick();
    in_item_t it;
    it = noise_item();
    it.op = OP_TICK;
    send_item(it);
  endtask

  // random descriptors only cover written words; the region [0, 4096) is filled first
  task automatic fill_region();
    for (int a = 0; a < 4096; a++) begin
      in_item_t it;
      it = noise_item();
      it.address = a[15:0];
      if (a < 8) it.sample_value = (a % 2) ? 16'sh8000 : 16'sh7fff;
      in_valid <= 1'b1;
      in_data <= it;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_directed();
    put_word(16'hffff, 16'sh7fff);
    put_desc(7'd127, 16'hfffe, 17'h10000, 2'd2, 20'd1);
    put_desc(7'd0, 16'd0, 17'd8, 2'd0, 20'hfffff);
    put_desc(7'd1, 16'd0, 17'd8, 2'd3, 20'd3);
    put_desc(7'd2, 16'd20, 17'd10, 2'd1, 20'd5);
    put_on(7'd5, 16'd1, 16'h8000);
    put_on(7'd127, 16'hffff, 16'hffff);
    put_on(7'd0, 16'd0, 16'h8000);
    put_on(7'd1, 16'd7, 16'd0);
    put_on(7'd2, 16'd9, 16'd100);
    put_tick();
    put_off(16'd7);
    put_off(16'd1234);
    put_tick();
    put_tick();
    for (int i = 0; i < 17; i++) put_on(7'd0, i[15:0], 16'h8000);
    put_tick();
    begin
      in_item_t it;
      it = noise_item();
      it.op = 3'd5 + $urandom_range(2);
      send_item(it);
    end
    for (int i = 0; i < 6; i++) put_tick();
  endtask

  task automatic random_block(int count);
    for (int k = 0; k < count; k++) begin
      int r;
      logic [15:0] a;
      r = $urandom_range(99);
      a = $urandom_range(4000);
      if (r < 10) put_word($urandom_range(4095), $urandom);
      else if (r < 22) put_desc($urandom_range(15), a, a + $urandom_range(60),
                                $urandom_range(3), $urandom_range(1, 300));
      else if (r < 24) put_desc($urandom_range(127), a, $urandom_range(4096),
                                $urandom_range(3), $urandom);
      else if (r < 42) put_on($urandom_range(17), $urandom_range(7), $urandom);
      else if (r < 52) put_off($urandom_range(7));
      else put_tick();
    end
  endtask

  task automatic test_pressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) put_tick();
    join
  endtask

  initial begin
    out_chans_reg = RESET_OUTPUT_CHANNELS;
    block_reg = RESET_BLOCK_FRAMES;
    floor_reg = RESET_RELEASE_FLOOR;
    frame_pos = 0;
    for (int i = 0; i < NSLOT; i++) v_mode[i] = MODE_IDLE;
    for (int i = 0; i < NSID; i++) sounds[i].ok = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fill_region();
    test_directed();
    settle();
    write_reg(CFG_BLOCK_FRAMES, 16'd1);
    write_reg(CFG_RELEASE_FLOOR, 16'd0);
    write_reg(CFG_OUTPUT_CHANNELS, 16'd1);
    send_idle = 61;
    random_block(180);
    settle();
    write_reg(CFG_OUTPUT_CHANNELS, 16'd0);
    write_reg(CFG_BLOCK_FRAMES, 16'd1024);
    write_reg(CFG_RELEASE_FLOOR, 16'd32768);
    send_idle = 0;
    recv_stall = 61;
    random_block(180);
    test_pressure();
    settle();
    write_reg(CFG_OUTPUT_CHANNELS, 16'd3);
    write_reg(CFG_BLOCK_FRAMES, 16'd2047);
    write_reg(CFG_RELEASE_FLOOR, 16'd328);
    send_idle = 31;
    recv_stall = 31;
    random_block(180);
    settle();
    write_reg(CFG_OUTPUT_CHANNELS, 16'd2);
    write_reg(CFG_BLOCK_FRAMES, 16'd0);
    write_reg(CFG_RELEASE_FLOOR, 16'd5000);
    random_block(90);
    settle();
    write_reg(CFG_BLOCK_FRAMES, 16'd3);
    send_idle = 0;
    recv_stall = 0;
    random_block(120);
    settle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/psvm_pkg.sv
rtl/psvm_ram.sv
rtl/psvm_fade.sv
rtl/psvm_front.sv
rtl/psvm_engine.sv
rtl/polyphonic_sample_voice_mixer.sv
tb/polyphonic_sample_voice_mixer_test.sv
